FILE: hdl/bres_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared constants, command codes and queue status type.
// ----------------------------------------------------------------------------
package bres_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int COLOUR_BITS    = 16;
	localparam int CMDQ_DEPTH     = 4;
	localparam int OUTQ_DEPTH     = 2;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: hdl/bres_fifo.sv
// ----------------------------------------------------------------------------
// Line pixel generator queue
// Small first-word-fall-through queue between pipeline parts.
// ----------------------------------------------------------------------------
module bres_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  pop,
	output logic [WIDTH-1:0]      rdata,
	output bres_pkg::q_status_t   status
);
	import bres_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rd_ptr_q];

	function automatic logic [IDX_W-1:0] next_ptr(input logic [IDX_W-1:0] p);
		logic [IDX_W-1:0] r;
		if (p == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

FILE: hdl/bres_front.sv
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts requests, classifies the line and prepares the walk set-up.
// ----------------------------------------------------------------------------
module bres_front #(
	parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic [COORD_BITS-1:0]           start_x,
	input  logic [COORD_BITS-1:0]           start_y,
	input  logic [COORD_BITS-1:0]           end_col,
	input  logic [COORD_BITS-1:0]           end_row,
	input  logic [bres_pkg::COLOUR_BITS-1:0] colour,
	input  bres_pkg::q_status_t             q_status,
	output logic                            q_push,
	output logic [3+6*COORD_BITS+bres_pkg::COLOUR_BITS-1:0] entry
);
	import bres_pkg::*;

	typedef struct packed {
		logic                   is_start;
		logic                   swapped;
		logic                   neg;
		logic [COORD_BITS-1:0]  major_pos;
		logic [COORD_BITS-1:0]  minor_pos;
		logic [COORD_BITS-1:0]  major_end;
		logic [COORD_BITS-1:0]  minor_delta;
		logic [COORD_BITS-1:0]  delta_gap;
		logic [COORD_BITS-1:0]  half_delta;
		logic [COLOUR_BITS-1:0] colour;
	} entry_t;

	// stage 1: raw endpoints, distances and orderings
	logic                   valid_s1;
	logic                   is_start_s1;
	logic [COORD_BITS-1:0]  x0_s1, y0_s1, x1_s1, y1_s1;
	logic [COORD_BITS-1:0]  dx_s1, dy_s1;
	logic                   x_gt_s1, x_lt_s1, y_gt_s1, y_lt_s1;
	logic [COLOUR_BITS-1:0] colour_s1;

	logic   valid_s2;
	entry_t entry_s2;
	entry_t entry_d;

	logic adv_s1;
	logic adv_s2;
	logic take;

	logic                  steep;
	logic                  ord;
	logic                  b_lt;
	logic [COORD_BITS-1:0] p0, p1, q0, q1, md, mnd;

	assign adv_s2 = !valid_s2 || !q_status.full;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign full   = !adv_s1;
	assign take   = push && !full;
	assign q_push = valid_s2;
	assign entry  = entry_s2;

	always_ff @(posedge clk) begin
		if (take) begin
			is_start_s1 <= (cmd_t'(cmd) == CMD_START);
			x0_s1       <= start_x;
			y0_s1       <= start_y;
			x1_s1       <= end_col;
			y1_s1       <= end_row;
			dx_s1       <= (start_x > end_col) ? start_x - end_col : end_col - start_x;
			dy_s1       <= (start_y > end_row) ? start_y - end_row : end_row - start_y;
			x_gt_s1     <= start_x > end_col;
			x_lt_s1     <= start_x < end_col;
			y_gt_s1     <= start_y > end_row;
			y_lt_s1     <= start_y < end_row;
			colour_s1   <= colour;
		end
	end

	// stage 2: pick the major axis and order endpoints along it
	always_comb begin
		steep = dy_s1 > dx_s1;
		p0    = steep ? y0_s1 : x0_s1;
		p1    = steep ? y1_s1 : x1_s1;
		q0    = steep ? x0_s1 : y0_s1;
		q1    = steep ? x1_s1 : y1_s1;
		md    = steep ? dy_s1 : dx_s1;
		mnd   = steep ? dx_s1 : dy_s1;
		ord   = steep ? y_gt_s1 : x_gt_s1;
		if (ord) begin
			b_lt = steep ? x_gt_s1 : y_gt_s1;
		end else begin
			b_lt = steep ? x_lt_s1 : y_lt_s1;
		end
		entry_d.is_start    = is_start_s1;
		entry_d.swapped     = steep;
		entry_d.neg         = !b_lt;
		entry_d.major_pos   = ord ? p1 : p0;
		entry_d.minor_pos   = ord ? q1 : q0;
		entry_d.major_end   = ord ? p0 : p1;
		entry_d.minor_delta = mnd;
		entry_d.delta_gap   = steep ? dy_s1 - dx_s1 : dx_s1 - dy_s1;
		entry_d.half_delta  = md >> 1;
		entry_d.colour      = colour_s1;
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			entry_s2 <= entry_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= take;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

endmodule

FILE: hdl/bres_back.sv
// ----------------------------------------------------------------------------
// Line pixel generator walk unit
// Holds the line state and produces one pixel per start request and per step while a line is active.
// ----------------------------------------------------------------------------
module bres_back #(
	parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bres_pkg::q_status_t  cmdq_status,
	input  logic [3+6*COORD_BITS+bres_pkg::COLOUR_BITS-1:0] cmdq_data,
	output logic                 cmdq_pop,
	input  bres_pkg::q_status_t  outq_status,
	output logic                 out_push,
	output logic [2*COORD_BITS+bres_pkg::COLOUR_BITS:0] out_data
);
	import bres_pkg::*;

	typedef struct packed {
		logic                   is_start;
		logic                   swapped;
		logic                   neg;
		logic [COORD_BITS-1:0]  major_pos;
		logic [COORD_BITS-1:0]  minor_pos;
		logic [COORD_BITS-1:0]  major_end;
		logic [COORD_BITS-1:0]  minor_delta;
		logic [COORD_BITS-1:0]  delta_gap;
		logic [COORD_BITS-1:0]  half_delta;
		logic [COLOUR_BITS-1:0] colour;
	} entry_t;

	entry_t entry;

	logic                   active_q;
	logic                   swapped_q;
	logic                   neg_q;
	logic [COORD_BITS-1:0]  major_pos_q;
	logic [COORD_BITS-1:0]  minor_pos_q;
	logic [COORD_BITS-1:0]  major_end_q;
	logic [COORD_BITS-1:0]  minor_delta_q;
	logic [COORD_BITS-1:0]  delta_gap_q;
	logic signed [COORD_BITS:0] error_acc_q;
	logic [COLOUR_BITS-1:0] colour_q;

	logic                   fire;
	logic                   produce;
	logic                   last;
	logic                   src_swapped, src_neg;
	logic [COORD_BITS-1:0]  src_major, src_minor, src_end, src_mnd, src_gap;
	logic signed [COORD_BITS:0] src_err, err_sub, err_alt;
	logic [COLOUR_BITS-1:0] src_colour;
	logic [COORD_BITS-1:0]  pix_x, pix_y;

	assign entry    = entry_t'(cmdq_data);
	assign fire     = !cmdq_status.empty && !outq_status.full;
	assign cmdq_pop = fire;
	assign produce  = entry.is_start || active_q;
	assign out_push = fire && produce;

	always_comb begin
		src_swapped = entry.is_start ? entry.swapped     : swapped_q;
		src_neg     = entry.is_start ? entry.neg         : neg_q;
		src_major   = entry.is_start ? entry.major_pos   : major_pos_q;
		src_minor   = entry.is_start ? entry.minor_pos   : minor_pos_q;
		src_end     = entry.is_start ? entry.major_end   : major_end_q;
		src_mnd     = entry.is_start ? entry.minor_delta : minor_delta_q;
		src_gap     = entry.is_start ? entry.delta_gap   : delta_gap_q;
		src_colour  = entry.is_start ? entry.colour      : colour_q;
		src_err     = entry.is_start ? $signed({1'b0, entry.half_delta}) : error_acc_q;
		last        = (src_major == src_end);
		// both outcomes of the error update side by side, then pick by sign
		err_sub     = src_err - $signed({1'b0, src_mnd});
		err_alt     = src_err + $signed({1'b0, src_gap});
		pix_x       = src_swapped ? src_minor : src_major;
		pix_y       = src_swapped ? src_major : src_minor;
		out_data    = {pix_x, pix_y, src_colour, last};
	end

	always_ff @(posedge clk) begin
		if (fire && produce) begin
			swapped_q     <= src_swapped;
			neg_q         <= src_neg;
			major_end_q   <= src_end;
			minor_delta_q <= src_mnd;
			delta_gap_q   <= src_gap;
			colour_q      <= src_colour;
			if (last) begin
				major_pos_q <= src_major;
				minor_pos_q <= src_minor;
				error_acc_q <= src_err;
			end else begin
				major_pos_q <= src_major + 1'b1;
				if (err_sub < 0) begin
					minor_pos_q <= src_neg ? src_minor - 1'b1 : src_minor + 1'b1;
					error_acc_q <= err_alt;
				end else begin
					minor_pos_q <= src_minor;
					error_acc_q <= err_sub;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (fire && produce) begin
			active_q <= !last;
		end
	end

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !entry.is_start && !active_q |-> !out_push)
		else $error("pixel produced for a step while idle");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_push && last |=> !active_q)
		else $error("line still active after its last pixel");

	a_error_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> error_acc_q >= 0)
		else $error("error accumulator went negative");

endmodule

FILE: hdl/bresenham_line_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// Line pixel generator
// Integer line walk producing one pixel coordinate per start request and per step while a line is active.
// ----------------------------------------------------------------------------
// A start request (cmd low) loads two endpoints and a colour and yields the
// first pixel of the line; each step request (cmd high) yields the next pixel,
// and the final pixel has last_pixel set. A step while no line is active is
// consumed without a result, and a start drops any line in progress. One
// request is taken per clock while full is low, and one pixel leaves per
// clock while empty is low and pop is high; the walk unit does one error-term
// update per cycle while the request queue holds an entry and the result
// queue has room, both update outcomes formed in parallel. A pixel passes two
// set-up stages and the request queue; the walk unit writes straight into the result queue.
module bresenham_line_pixel_generator_top #(
	parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             cmd,
	input  logic [COORD_BITS-1:0]            start_x,
	input  logic [COORD_BITS-1:0]            start_y,
	input  logic [COORD_BITS-1:0]            end_col,
	input  logic [COORD_BITS-1:0]            end_row,
	input  logic [bres_pkg::COLOUR_BITS-1:0] colour,
	output logic                             empty,
	input  logic                             pop,
	output logic [COORD_BITS-1:0]            pixel_x,
	output logic [COORD_BITS-1:0]            pixel_y,
	output logic [bres_pkg::COLOUR_BITS-1:0] pixel_colour,
	output logic                             last_pixel
);
	import bres_pkg::*;

	localparam int ENTRY_W = 3 + 6 * COORD_BITS + COLOUR_BITS;
	localparam int OUT_W   = 2 * COORD_BITS + COLOUR_BITS + 1;

	q_status_t          cmdq_status;
	q_status_t          outq_status;
	logic               cmdq_push;
	logic               cmdq_pop;
	logic [ENTRY_W-1:0] cmdq_wdata;
	logic [ENTRY_W-1:0] cmdq_rdata;
	logic               outq_push;
	logic [OUT_W-1:0]   outq_wdata;
	logic [OUT_W-1:0]   outq_rdata;

	bres_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_col  (end_col),
		.end_row  (end_row),
		.colour   (colour),
		.q_status (cmdq_status),
		.q_push   (cmdq_push),
		.entry    (cmdq_wdata)
	);

	bres_fifo #(.WIDTH(ENTRY_W), .DEPTH(CMDQ_DEPTH)) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmdq_push),
		.wdata  (cmdq_wdata),
		.pop    (cmdq_pop),
		.rdata  (cmdq_rdata),
		.status (cmdq_status)
	);

	bres_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmdq_status (cmdq_status),
		.cmdq_data   (cmdq_rdata),
		.cmdq_pop    (cmdq_pop),
		.outq_status (outq_status),
		.out_push    (outq_push),
		.out_data    (outq_wdata)
	);

	bres_fifo #(.WIDTH(OUT_W), .DEPTH(OUTQ_DEPTH)) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (outq_push),
		.wdata  (outq_wdata),
		.pop    (pop),
		.rdata  (outq_rdata),
		.status (outq_status)
	);

	assign empty = outq_status.empty;
	assign {pixel_x, pixel_y, pixel_colour, last_pixel} = outq_rdata;

endmodule

FILE: sim/bresenham_line_pixel_generator_top_test.sv
// ----------------------------------------------------------------------------
// Line pixel generator testbench
// Drives start and step requests through the push/full queue, predicts every
// pixel with an independent line walk, and checks each popped pixel in order
// while both sides stall in random bursts, until the run goes quiet.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator_top_test;
	import bres_pkg::*;

	localparam int CB           = COORD_BITS_DEF;
	localparam int HB           = COLOUR_BITS;
	localparam int RANDOM_ITEMS = 750;
	localparam int QUIET_ITEMS  = 680;
	localparam int STEP_CAP     = 60;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_CYCLES = 200000;

	typedef logic [CB-1:0] coord_t;

	typedef struct packed {
		coord_t        x;
		coord_t        y;
		logic [HB-1:0] colour;
		logic          last;
	} pixel_t;

	class line_walk_predictor;
		coord_t               walk_pos;
		coord_t               cross_pos;
		coord_t               walk_end;
		logic signed [CB:0]   err_term;
		coord_t               walk_delta;
		coord_t               cross_delta;
		logic                 cross_down;
		logic                 steep;
		logic                 active;
		logic [HB-1:0]        hue;
		pixel_t               pending_pixels[$];
		int                   mismatches;

		function new();
			walk_pos    = '0;
			cross_pos   = '0;
			walk_end    = '0;
			err_term    = '0;
			walk_delta  = '0;
			cross_delta = '0;
			cross_down  = 1'b0;
			steep       = 1'b0;
			active      = 1'b0;
			hue         = '0;
			mismatches  = 0;
		endfunction

		function coord_t span(coord_t a, coord_t b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void take_request(cmd_t op, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
				logic [HB-1:0] c);
			coord_t a0, b0, a1, b1, t;
			pixel_t px;
			if (op == CMD_START) begin
				steep = span(y1, y0) > span(x1, x0);
				if (steep) begin
					a0 = y0; b0 = x0; a1 = y1; b1 = x1;
				end else begin
					a0 = x0; b0 = y0; a1 = x1; b1 = y1;
				end
				// order the endpoints so the major coordinate only rises
				if (a0 > a1) begin
					t = a0; a0 = a1; a1 = t;
					t = b0; b0 = b1; b1 = t;
				end
				walk_pos    = a0;
				cross_pos   = b0;
				walk_end    = a1;
				walk_delta  = a1 - a0;
				cross_delta = span(b1, b0);
				cross_down  = !(b0 < b1);
				err_term    = {1'b0, walk_delta >> 1};
				hue         = c;
				active      = 1'b1;
			end
			if (!active)
				return;
			px.x      = steep ? cross_pos : walk_pos;
			px.y      = steep ? walk_pos : cross_pos;
			px.colour = hue;
			px.last   = (walk_pos == walk_end);
			pending_pixels.push_back(px);
			if (px.last) begin
				active = 1'b0;
			end else begin
				err_term = err_term - $signed({1'b0, cross_delta});
				if (err_term < 0) begin
					cross_pos = cross_down ? cross_pos - 1'b1 : cross_pos + 1'b1;
					err_term  = err_term + $signed({1'b0, walk_delta});
				end
				walk_pos = walk_pos + 1'b1;
			end
		endfunction

		function void check_pixel(coord_t x, coord_t y, logic [HB-1:0] c, logic last);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel x=%0d y=%0d colour=%h last=%0b", x, y, c, last);
				mismatches++;
				return;
			end
			want = pending_pixels.pop_front();
			if (x !== want.x) begin
				$error("pixel_x: expected %0d, actual %0d", want.x, x);
				mismatches++;
			end
			if (y !== want.y) begin
				$error("pixel_y: expected %0d, actual %0d", want.y, y);
				mismatches++;
			end
			if (c !== want.colour) begin
				$error("pixel_colour: expected %h, actual %h", want.colour, c);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last_pixel: expected %0b, actual %0b", want.last, last);
				mismatches++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	logic          cmd;
	coord_t        start_x;
	coord_t        start_y;
	coord_t        end_col;
	coord_t        end_row;
	logic [HB-1:0] colour;
	logic          empty;
	logic          pop;
	coord_t        pixel_x;
	coord_t        pixel_y;
	logic [HB-1:0] pixel_colour;
	logic          last_pixel;

	line_walk_predictor predictor;
	int                 issued;
	int                 push_gap_rate;
	int                 pop_gap_rate;
	bit                 quiet;

	bresenham_line_pixel_generator_top #(
		.COORD_BITS(CB)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_col     (end_col),
		.end_row     (end_row),
		.colour      (colour),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_colour(pixel_colour),
		.last_pixel  (last_pixel)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Present one request and hold it until the queue takes it.
	task automatic send_request(cmd_t op, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
			logic [HB-1:0] c);
		int gap;
		if (!quiet && $urandom_range(0, 15) < push_gap_rate) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push    <= 1'b1;
		cmd     <= op;
		start_x <= x0;
		start_y <= y0;
		end_col <= x1;
		end_row <= y1;
		colour  <= c;
		do @(posedge clk); while (full);
		predictor.take_request(op, x0, y0, x1, y1, c);
	endtask

	task automatic send_step();
		send_request(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), HB'($urandom));
	endtask

	task automatic send_steps(int n);
		repeat (n) send_step();
	endtask

	// One random line: start, then mostly a full walk, sometimes an early abort
	// or a few surplus steps that land on an idle walker.
	task automatic send_random_line();
		coord_t x0, y0, x1, y1;
		int     len;
		int     n;
		int     pick;
		x0 = coord_t'($urandom);
		y0 = coord_t'($urandom);
		if ($urandom_range(0, 19) == 0) begin
			x1 = coord_t'($urandom);
			y1 = coord_t'($urandom);
		end else begin
			x1 = x0 + coord_t'($urandom_range(0, 40)) - coord_t'(20);
			y1 = y0 + coord_t'($urandom_range(0, 40)) - coord_t'(20);
		end
		len  = int'(predictor.span(x1, x0) > predictor.span(y1, y0) ?
			predictor.span(x1, x0) : predictor.span(y1, y0));
		pick = $urandom_range(0, 19);
		if (pick < 14)
			n = len;
		else if (pick < 17)
			n = $urandom_range(0, len);
		else
			n = len + $urandom_range(1, 3);
		if (n > STEP_CAP)
			n = $urandom_range(0, STEP_CAP);
		send_request(CMD_START, x0, y0, x1, y1, HB'($urandom));
		send_steps(n);
		issued += 1 + ((n < len) ? n : len);
	endtask

	// Result side: pop with random stall bursts, none once the run goes quiet.
	initial begin
		int stall_left;
		int cyc;
		stall_left = 0;
		cyc        = 0;
		pop        = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 200 == 0)
				pop_gap_rate = $urandom_range(0, 2) * 3;
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) < pop_gap_rate) begin
				stall_left = $urandom_range(1, 15) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			predictor.check_pixel(pixel_x, pixel_y, pixel_colour, last_pixel);
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("bresenham_line_pixel_generator_top_test failed");
		$finish;
	end

	initial begin
		predictor     = new();
		issued        = 0;
		quiet         = 1'b0;
		push_gap_rate = 3;
		pop_gap_rate  = 3;
		arst_n        = 1'b0;
		push          = 1'b0;
		cmd           = CMD_START;
		start_x       = '0;
		start_y       = '0;
		end_col       = '0;
		end_row       = '0;
		colour        = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// step with no line active: consumed, nothing comes out
		send_step();
		// single point at the far corner
		send_request(CMD_START, '1, '1, '1, '1, 16'hffff);
		send_step();
		// shallow line given right to left; walked left to right, minor axis falling
		send_request(CMD_START, 10'd1023, 10'd0, 10'd1020, 10'd2, 16'h0000);
		send_steps(3);
		// steep line, minor axis falling
		send_request(CMD_START, 10'd2, 10'd0, 10'd0, 10'd3, 16'h8421);
		send_steps(3);
		// full-extent diagonal, dropped after two steps by a vertical line
		send_request(CMD_START, 10'd0, 10'd1023, 10'd1023, 10'd0, 16'h7bde);
		send_steps(2);
		send_request(CMD_START, 10'd0, 10'd0, 10'd0, 10'd2, 16'h5555);
		send_steps(2);
		send_step();
		// horizontal line left to right
		send_request(CMD_START, 10'd0, 10'd0, 10'd3, 10'd0, 16'haaaa);
		send_steps(3);

		while (issued < RANDOM_ITEMS) begin
			if (issued >= QUIET_ITEMS)
				quiet = 1'b1;
			else if ($urandom_range(0, 9) == 0)
				push_gap_rate = $urandom_range(0, 2) * 3;
			if ($urandom_range(0, 9) == 0)
				send_step();
			send_random_line();
		end

		@(negedge clk);
		push <= 1'b0;
		while (predictor.pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (predictor.mismatches == 0)
			$display("bresenham_line_pixel_generator_top_test passed");
		else
			$display("bresenham_line_pixel_generator_top_test failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/bres_pkg.sv
hdl/bres_fifo.sv
hdl/bres_front.sv
hdl/bres_back.sv
hdl/bresenham_line_pixel_generator_top.sv
sim/bresenham_line_pixel_generator_top_test.sv
